[rtl/olist_pkg.sv]
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants of the ordered list engine: item layouts,
// operation and status codes, sequencer states and the per-cell control.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CHECK  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ORDER_UNSORTED = 2'd0,
    ORDER_SORTED   = 2'd1,
    ORDER_EMPTY    = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_COMPARE = 2'd1,
    S_ISOLATE = 2'd2,
    S_FINISH  = 2'd3
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  position;
    order_t      order_state;
    logic [6:0]  entry_count;
  } rsp_item_t;

  // Control from the sequencer to one cell
  typedef struct packed {
    logic in_range;  // cell holds a live entry
    logic pair_ok;   // cell and its upper neighbor both live
    logic wr;        // load the key as new tail
    logic shift;     // take the neighbor's entry
  } cell_ctl_t;

  // Flags from one cell back to the sequencer
  typedef struct packed {
    logic hit;
    logic viol;
  } cell_sts_t;

endpackage

[rtl/olist_cell.sv]
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds an entry, compares it with the broadcast key and with
// the next slot's entry, and loads the key or the neighbor's entry on command.
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  olist_pkg::cell_ctl_t             ctl,
  input  logic signed [olist_pkg::DATA_W-1:0] key,
  input  logic signed [olist_pkg::DATA_W-1:0] nxt,
  output logic signed [olist_pkg::DATA_W-1:0] entry,
  output olist_pkg::cell_sts_t             sts
);

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      entry <= key;
    end else if (ctl.shift) begin
      entry <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
    end else begin
      sts.hit  <= ctl.in_range && (entry == key);
      sts.viol <= ctl.pair_ok && (entry > nxt);
    end
  end

endmodule

[rtl/olist_ctrl.sv]
// ----------------------------------------------------------------------------
// olist_ctrl
// Sequencer of the list: takes an item, steers the cells through compare,
// first-hit isolation and commit, keeps the count and holds the result.
// ----------------------------------------------------------------------------
module olist_ctrl (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       req_valid,
  output logic                                       req_stall,
  input  olist_pkg::req_item_t                       req,
  output logic                                       rsp_valid,
  input  logic                                       rsp_stall,
  output olist_pkg::rsp_item_t                       rsp,
  output logic signed [olist_pkg::DATA_W-1:0]        key,
  output olist_pkg::cell_ctl_t [olist_pkg::MAX_ENTRIES-1:0] ctl,
  input  olist_pkg::cell_sts_t [olist_pkg::MAX_ENTRIES-1:0] sts
);

  localparam int N = olist_pkg::MAX_ENTRIES;

  olist_pkg::state_t              state;
  olist_pkg::state_t              state_next;
  olist_pkg::mode_t               mode;
  logic [olist_pkg::CNT_W-1:0]    count;
  logic [olist_pkg::CNT_W-1:0]    count_next;
  logic [N-1:0]                   hits;
  logic [N-1:0]                   ge_mask;
  logic [N-1:0]                   onehot;
  logic [olist_pkg::IDX_W-1:0]    hit_idx;
  logic                           found;
  logic                           full;
  logic                           commit;
  olist_pkg::rsp_item_t           rsp_next;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      hits[i] = sts[i].hit;
    end
  end

  assign found    = |onehot;
  assign full     = (count == olist_pkg::CNT_W'(N));
  assign commit   = (state == olist_pkg::S_FINISH) && (!rsp_valid || !rsp_stall);

  // next state
  always_comb begin
    case (state)
      olist_pkg::S_IDLE:    state_next = req_valid ? olist_pkg::S_COMPARE : olist_pkg::S_IDLE;
      olist_pkg::S_COMPARE: state_next = olist_pkg::S_ISOLATE;
      olist_pkg::S_ISOLATE: state_next = olist_pkg::S_FINISH;
      olist_pkg::S_FINISH:  state_next = commit ? olist_pkg::S_IDLE : olist_pkg::S_FINISH;
      default:              state_next = olist_pkg::S_IDLE;
    endcase
  end

  // outputs toward the cells and the request side
  always_comb begin
    req_stall = (state != olist_pkg::S_IDLE);
    for (int i = 0; i < N; i++) begin
      ctl[i].in_range = (olist_pkg::CNT_W'(i) < count);
      ctl[i].pair_ok  = (olist_pkg::CNT_W'(i + 1) < count);
      ctl[i].wr       = commit && (mode == olist_pkg::MODE_APPEND) && !full
                        && (olist_pkg::CNT_W'(i) == count);
      ctl[i].shift    = commit && (mode == olist_pkg::MODE_REMOVE) && ge_mask[i];
    end
  end

  // encode the isolated first hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        hit_idx = hit_idx | olist_pkg::IDX_W'(i);
      end
    end
  end

  logic viol_seen;
  always_comb begin
    viol_seen = 1'b0;
    for (int i = 0; i < N; i++) begin
      viol_seen = viol_seen | sts[i].viol;
    end
  end

  always_comb begin
    rsp_next             = '0;
    rsp_next.status      = olist_pkg::STATUS_OK;
    rsp_next.order_state = olist_pkg::ORDER_UNSORTED;
    count_next           = count;
    case (mode)
      olist_pkg::MODE_APPEND: begin
        if (full) begin
          rsp_next.status = olist_pkg::STATUS_FULL;
        end else begin
          count_next = count + olist_pkg::CNT_W'(1);
        end
      end
      olist_pkg::MODE_SEARCH: begin
        if (found) begin
          rsp_next.position = 6'(hit_idx);
        end else begin
          rsp_next.status = olist_pkg::STATUS_MISS;
        end
      end
      olist_pkg::MODE_REMOVE: begin
        if (found) begin
          rsp_next.position = 6'(hit_idx);
          count_next        = count - olist_pkg::CNT_W'(1);
        end else begin
          rsp_next.status = olist_pkg::STATUS_MISS;
        end
      end
      olist_pkg::MODE_CHECK: begin
        if (count == '0) begin
          rsp_next.order_state = olist_pkg::ORDER_EMPTY;
        end else if (viol_seen) begin
          rsp_next.order_state = olist_pkg::ORDER_UNSORTED;
        end else begin
          rsp_next.order_state = olist_pkg::ORDER_SORTED;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.entry_count = 7'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olist_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == olist_pkg::S_IDLE && req_valid) begin
      mode <= req.mode;
      key  <= req.value;
    end
    if (state == olist_pkg::S_ISOLATE) begin
      // lowest set bit and everything above it
      ge_mask <= hits | (~hits + N'(1));
      onehot  <= hits & (~hits + N'(1));
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

[rtl/ordered_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded list of signed 32-bit values in insertion order, with append,
// search, remove-first-match and sorted check.
// ----------------------------------------------------------------------------
// Each list slot is a cell that compares its entry with the item's value and
// with its upper neighbor; the sequencer then isolates the first hit and
// commits. The sequencer steps each item through accept, compare, isolate
// and commit and takes no new item until the last is committed; the
// result sits in an output register, so a stalled result holds the block only
// at commit. Removal shifts all later cells down by one in the commit cycle.
// Slots are not cleared at reset; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  olist_pkg::req_item_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output olist_pkg::rsp_item_t rsp
);

  localparam int N = olist_pkg::MAX_ENTRIES;

  logic signed [olist_pkg::DATA_W-1:0]        key;
  logic signed [olist_pkg::DATA_W-1:0]        cell_val [N];
  olist_pkg::cell_ctl_t [N-1:0]               ctl;
  olist_pkg::cell_sts_t [N-1:0]               sts;

  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .key       (key),
    .ctl       (ctl),
    .sts       (sts)
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [olist_pkg::DATA_W-1:0] nxt;
    if (g == N - 1) begin : g_top
      assign nxt = cell_val[g];
    end else begin : g_mid
      assign nxt = cell_val[g + 1];
    end

    olist_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl[g]),
      .key   (key),
      .nxt   (nxt),
      .entry (cell_val[g]),
      .sts   (sts[g])
    );
  end

endmodule
